// File: rtl/sbcc_pkg.sv
// Package for the send backoff credit controller: config types, codes and reset values.
`timescale 1ns / 1ps

package sbcc_pkg;

    // Field widths
    localparam int unsigned IVL_W    = 20;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CREDIT_W = 12;
    localparam int unsigned BASE_W   = 16;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned RES_W    = 3;
    localparam int unsigned JIT_W    = 3;

    // APB register map
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam logic [2:0] REG_NET_ERROR_LIMIT   = 3'd0;
    localparam logic [2:0] REG_NET_RETRY_BASE    = 3'd1;
    localparam logic [2:0] REG_NET_RETRY_MAX     = 3'd2;
    localparam logic [2:0] REG_QUOTA_ERROR_LIMIT = 3'd3;
    localparam logic [2:0] REG_QUOTA_RETRY_BASE  = 3'd4;
    localparam logic [2:0] REG_QUOTA_RETRY_MAX   = 3'd5;
    localparam logic [2:0] REG_CREDIT_MAX        = 3'd6;
    localparam logic [2:0] REG_CREDIT_TRIGGER    = 3'd7;

    // Register reset values
    localparam logic [CNT_W-1:0]    RST_NET_ERROR_LIMIT   = 8'd60;
    localparam logic [BASE_W-1:0]   RST_NET_RETRY_BASE    = 16'd300;
    localparam logic [BASE_W-1:0]   RST_NET_RETRY_MAX     = 16'd3600;
    localparam logic [CNT_W-1:0]    RST_QUOTA_ERROR_LIMIT = 8'd1;
    localparam logic [BASE_W-1:0]   RST_QUOTA_RETRY_BASE  = 16'd3;
    localparam logic [BASE_W-1:0]   RST_QUOTA_RETRY_MAX   = 16'd60;
    localparam logic [CREDIT_W-1:0] RST_CREDIT_MAX        = 12'd512;
    localparam logic [CREDIT_W-1:0] RST_CREDIT_TRIGGER    = 12'd256;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_CAN_SEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECORD      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RECOVER     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CONCURRENCY = 2'd3;

    // Send results
    localparam logic [RES_W-1:0] RES_OK         = 3'd0;
    localparam logic [RES_W-1:0] RES_DISCARD    = 3'd1;
    localparam logic [RES_W-1:0] RES_NET_FAIL   = 3'd2;
    localparam logic [RES_W-1:0] RES_QUOTA_FAIL = 3'd3;

    localparam logic [JIT_W-1:0] JIT_MAX = 3'd4;

    // Configuration register set
    typedef struct packed {
        logic [CNT_W-1:0]    net_error_limit;
        logic [BASE_W-1:0]   net_retry_base;
        logic [BASE_W-1:0]   net_retry_max;
        logic [CNT_W-1:0]    quota_error_limit;
        logic [BASE_W-1:0]   quota_retry_base;
        logic [BASE_W-1:0]   quota_retry_max;
        logic [CREDIT_W-1:0] credit_max;
        logic [CREDIT_W-1:0] credit_trigger;
    } sbcc_cfg_t;

endpackage

// File: rtl/sbcc_cfg.sv
// APB register file holding the breaker and credit configuration.
`timescale 1ns / 1ps

module sbcc_cfg
    import sbcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output sbcc_cfg_t          cfg
);

    sbcc_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write one register per access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.net_error_limit   <= RST_NET_ERROR_LIMIT;
            cfg_reg.net_retry_base    <= RST_NET_RETRY_BASE;
            cfg_reg.net_retry_max     <= RST_NET_RETRY_MAX;
            cfg_reg.quota_error_limit <= RST_QUOTA_ERROR_LIMIT;
            cfg_reg.quota_retry_base  <= RST_QUOTA_RETRY_BASE;
            cfg_reg.quota_retry_max   <= RST_QUOTA_RETRY_MAX;
            cfg_reg.credit_max        <= RST_CREDIT_MAX;
            cfg_reg.credit_trigger    <= RST_CREDIT_TRIGGER;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NET_ERROR_LIMIT:   cfg_reg.net_error_limit   <= pwdata[CNT_W-1:0];
                REG_NET_RETRY_BASE:    cfg_reg.net_retry_base    <= pwdata[BASE_W-1:0];
                REG_NET_RETRY_MAX:     cfg_reg.net_retry_max     <= pwdata[BASE_W-1:0];
                REG_QUOTA_ERROR_LIMIT: cfg_reg.quota_error_limit <= pwdata[CNT_W-1:0];
                REG_QUOTA_RETRY_BASE:  cfg_reg.quota_retry_base  <= pwdata[BASE_W-1:0];
                REG_QUOTA_RETRY_MAX:   cfg_reg.quota_retry_max   <= pwdata[BASE_W-1:0];
                REG_CREDIT_MAX:        cfg_reg.credit_max        <= pwdata[CREDIT_W-1:0];
                REG_CREDIT_TRIGGER:    cfg_reg.credit_trigger    <= pwdata[CREDIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_NET_ERROR_LIMIT:   prdata = PDATA_W'(cfg_reg.net_error_limit);
            REG_NET_RETRY_BASE:    prdata = PDATA_W'(cfg_reg.net_retry_base);
            REG_NET_RETRY_MAX:     prdata = PDATA_W'(cfg_reg.net_retry_max);
            REG_QUOTA_ERROR_LIMIT: prdata = PDATA_W'(cfg_reg.quota_error_limit);
            REG_QUOTA_RETRY_BASE:  prdata = PDATA_W'(cfg_reg.quota_retry_base);
            REG_QUOTA_RETRY_MAX:   prdata = PDATA_W'(cfg_reg.quota_retry_max);
            REG_CREDIT_MAX:        prdata = PDATA_W'(cfg_reg.credit_max);
            REG_CREDIT_TRIGGER:    prdata = PDATA_W'(cfg_reg.credit_trigger);
            default:               prdata = '0;
        endcase
    end

endmodule

// File: rtl/send_backoff_credit_controller.sv
// Top level: sender health breakers with exponential backoff and send credit.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_tvalid/s_tready  s_tuser: req_type; s_tdata: request fields
//   m_       out        m_tvalid/m_tready  m_tdata: answer, breaker flags, credit
//   APB      in         psel/penable       eight configuration registers at 4*i
//
// Each request yields one result transaction. A request is held in the input
// register, is evaluated against the breaker state in one pass and lands in
// the output register; one request per cycle is sustained while the output drains.
// Reset (aresetn low, synchronous) restores configuration and breaker state.
// A stalled output holds its transaction; the input register keeps accepting
// as long as the output register drains.
`timescale 1ns / 1ps

module send_backoff_credit_controller
    import sbcc_pkg::*;
#(
    parameter int unsigned FRAC_BITS      = 4,
    parameter int unsigned NET_SCALE_Q4   = 24,
    parameter int unsigned QUOTA_SCALE_Q4 = 32,
    parameter int unsigned CREDIT_MIN     = 1,
    parameter int unsigned IDLE_LIMIT     = 300
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,  // now_time[31:0], send_result[34:32],
                                         // jitter[37:35], region_match[38]
    input  logic [1:0]         s_tuser,  // req_type[1:0]
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,  // answer[0], network_ok[1], quota_ok[2],
                                         // credit[14:3]
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned PROD_W = 28;

    sbcc_cfg_t cfg;

    // Input register
    logic                in_valid_reg;
    logic [REQ_W-1:0]    in_req_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic [RES_W-1:0]    in_res_reg;
    logic [JIT_W-1:0]    in_jit_reg;
    logic                in_match_reg;

    // Breaker and credit state
    logic [CNT_W-1:0]    net_cnt_reg,    net_cnt_next;
    logic [CNT_W-1:0]    quota_cnt_reg,  quota_cnt_next;
    logic [TIME_W-1:0]   net_time_reg,   net_time_next;
    logic [TIME_W-1:0]   quota_time_reg, quota_time_next;
    logic [IVL_W-1:0]    net_ivl_reg,    net_ivl_next;
    logic [IVL_W-1:0]    quota_ivl_reg,  quota_ivl_next;
    logic                net_closed_reg, net_closed_next;
    logic                quota_closed_reg, quota_closed_next;
    logic [CREDIT_W-1:0] credit_reg,     credit_next;
    logic [TIME_W-1:0]   credit_time_reg, credit_time_next;

    // Output register
    logic                m_valid_reg;
    logic [15:0]         m_data_reg;

    logic                s_fire;
    logic                proc_fire;
    logic                ans;
    logic                net_due, quota_due, idle_due;
    logic [JIT_W-1:0]    jit_clip;
    logic [IVL_W-1:0]    net_base_ivl, quota_base_ivl;
    logic [IVL_W-1:0]    net_grown_ivl, quota_grown_ivl;
    logic [CNT_W-1:0]    net_cnt_inc, quota_cnt_inc;
    logic [CREDIT_W:0]   credit_p1, credit_p2;

    // Scale an interval by a Q4 factor, clamp at max seconds, saturate to width
    function automatic logic [IVL_W-1:0] grow_ivl(input logic [IVL_W-1:0]  ivl,
                                                   input logic [PROD_W-1:0] scale,
                                                   input logic [BASE_W-1:0] maxsec);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] lim;
        logic [PROD_W-1:0] v;
        prod = (PROD_W'(ivl) * scale) >> 4;
        lim  = PROD_W'(maxsec) << FRAC_BITS;
        v    = (prod > lim) ? lim : prod;
        return (v > PROD_W'({IVL_W{1'b1}})) ? {IVL_W{1'b1}} : v[IVL_W-1:0];
    endfunction

    // Shift whole seconds into fixed point, saturating
    function automatic logic [IVL_W-1:0] to_ivl(input logic [BASE_W:0] sec);
        logic [PROD_W-1:0] v;
        v = PROD_W'(sec) << FRAC_BITS;
        return (v > PROD_W'({IVL_W{1'b1}})) ? {IVL_W{1'b1}} : v[IVL_W-1:0];
    endfunction

    sbcc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshakes
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Capture the request transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg   <= s_tuser[1:0];
            in_now_reg   <= s_tdata[31:0];
            in_res_reg   <= s_tdata[34:32];
            in_jit_reg   <= s_tdata[37:35];
            in_match_reg <= s_tdata[38];
        end
    end

    // Shared terms for this request
    always_comb begin
        net_due   = (in_now_reg - net_time_reg) >= TIME_W'(net_ivl_reg >> FRAC_BITS);
        quota_due = (in_now_reg - quota_time_reg) >= TIME_W'(quota_ivl_reg >> FRAC_BITS);
        idle_due  = (in_now_reg - credit_time_reg) > TIME_W'(IDLE_LIMIT);
        jit_clip  = (in_jit_reg > JIT_MAX) ? JIT_MAX : in_jit_reg;
        net_base_ivl    = to_ivl({1'b0, cfg.net_retry_base});
        quota_base_ivl  = to_ivl({1'b0, cfg.quota_retry_base} + (BASE_W+1)'(jit_clip));
        net_grown_ivl   = grow_ivl(net_ivl_reg, PROD_W'(NET_SCALE_Q4), cfg.net_retry_max);
        quota_grown_ivl = grow_ivl(quota_ivl_reg, PROD_W'(QUOTA_SCALE_Q4),
                                   cfg.quota_retry_max);
        net_cnt_inc   = (net_cnt_reg != {CNT_W{1'b1}}) ? net_cnt_reg + 1'b1 : net_cnt_reg;
        quota_cnt_inc = (quota_cnt_reg != {CNT_W{1'b1}}) ? quota_cnt_reg + 1'b1
                                                         : quota_cnt_reg;
        credit_p1 = {1'b0, credit_reg} + (CREDIT_W+1)'(1);
        credit_p2 = {1'b0, credit_reg} + (CREDIT_W+1)'(2);
    end

    // Evaluate the request against the breaker state
    always_comb begin
        net_cnt_next      = net_cnt_reg;
        quota_cnt_next    = quota_cnt_reg;
        net_time_next     = net_time_reg;
        quota_time_next   = quota_time_reg;
        net_ivl_next      = net_ivl_reg;
        quota_ivl_next    = quota_ivl_reg;
        net_closed_next   = net_closed_reg;
        quota_closed_next = quota_closed_reg;
        credit_next       = credit_reg;
        credit_time_next  = credit_time_reg;
        ans               = 1'b0;

        case (in_req_reg)
            REQ_CAN_SEND: begin
                ans = 1'b1;
                if (!net_closed_reg) begin
                    if (net_due) begin
                        net_ivl_next    = net_grown_ivl;
                        net_time_next   = in_now_reg;
                        net_cnt_next    = '0;
                        net_closed_next = 1'b1;
                    end else begin
                        ans = 1'b0;
                    end
                end else if (!quota_closed_reg) begin
                    if (quota_due) begin
                        quota_ivl_next    = quota_grown_ivl;
                        quota_time_next   = in_now_reg;
                        quota_cnt_next    = '0;
                        quota_closed_next = 1'b1;
                    end else begin
                        ans = 1'b0;
                    end
                end
            end
            REQ_RECORD: begin
                case (in_res_reg)
                    RES_OK, RES_DISCARD: begin
                        net_cnt_next      = '0;
                        quota_cnt_next    = '0;
                        net_closed_next   = 1'b1;
                        quota_closed_next = 1'b1;
                        net_ivl_next      = net_base_ivl;
                        quota_ivl_next    = quota_base_ivl;
                        if (credit_p2 > (CREDIT_W+1)'(cfg.credit_max)) begin
                            credit_next = cfg.credit_max;
                        end else begin
                            credit_next      = credit_p2[CREDIT_W-1:0];
                            credit_time_next = in_now_reg;
                        end
                        ans = credit_next < cfg.credit_trigger;
                    end
                    RES_NET_FAIL: begin
                        net_time_next = in_now_reg;
                        if (credit_p1 > (CREDIT_W+1)'(cfg.credit_max)) begin
                            credit_next = cfg.credit_max;
                        end else begin
                            credit_next      = credit_p1[CREDIT_W-1:0];
                            credit_time_next = in_now_reg;
                        end
                        net_cnt_next = net_cnt_inc;
                        if (net_cnt_inc >= cfg.net_error_limit) begin
                            net_cnt_next    = cfg.net_error_limit;
                            net_closed_next = 1'b0;
                        end
                    end
                    RES_QUOTA_FAIL: begin
                        quota_time_next  = in_now_reg;
                        credit_next      = CREDIT_W'(CREDIT_MIN);
                        credit_time_next = in_now_reg;
                        quota_cnt_next   = quota_cnt_inc;
                        if (quota_cnt_inc >= cfg.quota_error_limit) begin
                            quota_cnt_next    = cfg.quota_error_limit;
                            quota_closed_next = 1'b0;
                        end
                    end
                    default: begin
                        if (credit_p1 > (CREDIT_W+1)'(cfg.credit_max)) begin
                            credit_next = cfg.credit_max;
                        end else begin
                            credit_next      = credit_p1[CREDIT_W-1:0];
                            credit_time_next = in_now_reg;
                        end
                    end
                endcase
            end
            REQ_RECOVER: begin
                if (in_match_reg) begin
                    ans               = !(net_closed_reg && quota_closed_reg);
                    net_cnt_next      = '0;
                    quota_cnt_next    = '0;
                    net_closed_next   = 1'b1;
                    quota_closed_next = 1'b1;
                    net_ivl_next      = net_base_ivl;
                    quota_ivl_next    = quota_base_ivl;
                    if (credit_p2 > (CREDIT_W+1)'(cfg.credit_max)) begin
                        credit_next = cfg.credit_max;
                    end else begin
                        credit_next      = credit_p2[CREDIT_W-1:0];
                        credit_time_next = in_now_reg;
                    end
                end
            end
            default: begin
                // Refill an idle, exhausted credit
                if ((credit_reg == '0) && idle_due) begin
                    credit_next      = CREDIT_W'(CREDIT_MIN);
                    credit_time_next = in_now_reg;
                end
                ans = credit_next != '0;
            end
        endcase
    end

    // Advance breaker state once per processed request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_cnt_reg      <= '0;
            quota_cnt_reg    <= '0;
            net_time_reg     <= '0;
            quota_time_reg   <= '0;
            net_ivl_reg      <= to_ivl({1'b0, RST_NET_RETRY_BASE});
            quota_ivl_reg    <= to_ivl({1'b0, RST_QUOTA_RETRY_BASE});
            net_closed_reg   <= 1'b1;
            quota_closed_reg <= 1'b1;
            credit_reg       <= RST_CREDIT_MAX;
            credit_time_reg  <= '0;
        end else if (proc_fire) begin
            net_cnt_reg      <= net_cnt_next;
            quota_cnt_reg    <= quota_cnt_next;
            net_time_reg     <= net_time_next;
            quota_time_reg   <= quota_time_next;
            net_ivl_reg      <= net_ivl_next;
            quota_ivl_reg    <= quota_ivl_next;
            net_closed_reg   <= net_closed_next;
            quota_closed_reg <= quota_closed_next;
            credit_reg       <= credit_next;
            credit_time_reg  <= credit_time_next;
        end
    end

    // Hold the result transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            m_data_reg <= {1'b0, credit_next, quota_closed_next, net_closed_next, ans};
        end
    end

endmodule

// File: verif/tb.sv
// Self-checking testbench for the send backoff credit controller: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import sbcc_pkg::*;

    localparam int unsigned BACKOFF_FRAC     = 4;
    localparam int unsigned NET_GROWTH_Q4    = 24;
    localparam int unsigned QUOTA_GROWTH_Q4  = 32;
    localparam int unsigned CREDIT_FLOOR     = 1;
    localparam int unsigned IDLE_REFILL_SECS = 300;
    localparam int unsigned ITEMS_PER_BLOCK  = 305;
    localparam int unsigned HOLD_CYCLES      = 200;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_time;
        logic [2:0]  send_result;
        logic [2:0]  jitter;
        logic        region_match;
    } request_t;

    typedef struct packed {
        logic        answer;
        logic        network_ok;
        logic        quota_ok;
        logic [11:0] credit;
    } health_t;

    typedef struct {
        bit          is_write;
        logic [2:0]  reg_idx;
        logic [31:0] reg_value;
        request_t    req;
        bit          known;
        health_t     want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // now_time[31:0], send_result[34:32], jitter[37:35], region_match[38]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // answer[0], network_ok[1], quota_ok[2], credit[14:3]
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow configuration and breaker state of the predictor
    sbcc_cfg_t   shadow_cfg;
    logic [7:0]  net_err_cnt, quota_err_cnt;
    logic [31:0] net_err_time, quota_err_time, credit_stamp;
    logic [19:0] net_backoff, quota_backoff;
    logic        net_up, quota_up;
    logic [11:0] credit_level;

    health_t     expected_health[$];
    int          fail_count = 0;
    int unsigned src_gap_pct = 0;
    int unsigned sink_gap_pct = 0;
    bit          hold_request = 0;

    send_backoff_credit_controller #(
        .FRAC_BITS      (BACKOFF_FRAC),
        .NET_SCALE_Q4   (NET_GROWTH_Q4),
        .QUOTA_SCALE_Q4 (QUOTA_GROWTH_Q4),
        .CREDIT_MIN     (CREDIT_FLOOR),
        .IDLE_LIMIT     (IDLE_REFILL_SECS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Limit the run
    initial begin
        #(2_000_000);
        $display("send_backoff_credit_controller regression: fail");
        $finish;
    end

    function automatic logic [19:0] clamp_backoff(input logic [63:0] v);
        return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    // Scale an interval by a Q4 factor, capped at the configured maximum
    function automatic logic [19:0] grow_backoff(input logic [19:0] ivl,
                                                 input int unsigned scale,
                                                 input logic [15:0] max_s);
        logic [63:0] v;
        logic [63:0] cap;
        v   = (64'(ivl) * 64'(scale)) >> 4;
        cap = 64'(max_s) << BACKOFF_FRAC;
        if (v > cap) v = cap;
        return clamp_backoff(v);
    endfunction

    // Raise the credit; past the maximum it sticks at the maximum and keeps its stamp
    function automatic void add_credit(input int unsigned amount, input logic [31:0] now);
        logic [31:0] c;
        c = 32'(credit_level) + amount;
        if (c > 32'(shadow_cfg.credit_max)) begin
            credit_level = shadow_cfg.credit_max;
        end else begin
            credit_level = c[11:0];
            credit_stamp = now;
        end
    endfunction

    // Returns {tripped, new count}
    function automatic logic [8:0] count_failure(input logic [7:0] cnt, input logic [7:0] limit);
        logic [7:0] c;
        c = (cnt < 8'd255) ? cnt + 8'd1 : cnt;
        if (c >= limit) return {1'b1, limit};
        return {1'b0, c};
    endfunction

    function automatic void settle_success(input logic [31:0] now, input logic [2:0] jit);
        logic [2:0] j;
        j = (jit > JIT_MAX) ? JIT_MAX : jit;
        net_err_cnt   = '0;
        quota_err_cnt = '0;
        net_up        = 1'b1;
        quota_up      = 1'b1;
        net_backoff   = clamp_backoff(64'(shadow_cfg.net_retry_base) << BACKOFF_FRAC);
        quota_backoff = clamp_backoff((64'(shadow_cfg.quota_retry_base) + 64'(j))
                                      << BACKOFF_FRAC);
        add_credit(2, now);
    endfunction

    // Advance the breaker state by one request and return its result
    function automatic health_t next_health(input request_t r);
        health_t     h;
        logic [8:0]  trip;
        logic [31:0] elapsed;
        h = '0;
        case (r.req_type)
            REQ_CAN_SEND: begin
                h.answer = 1'b1;
                if (!net_up) begin
                    elapsed = r.now_time - net_err_time;
                    if (elapsed >= 32'(net_backoff >> BACKOFF_FRAC)) begin
                        net_backoff  = grow_backoff(net_backoff, NET_GROWTH_Q4,
                                                    shadow_cfg.net_retry_max);
                        net_err_time = r.now_time;
                        net_err_cnt  = '0;
                        net_up       = 1'b1;
                    end else begin
                        h.answer = 1'b0;
                    end
                end else if (!quota_up) begin
                    elapsed = r.now_time - quota_err_time;
                    if (elapsed >= 32'(quota_backoff >> BACKOFF_FRAC)) begin
                        quota_backoff  = grow_backoff(quota_backoff, QUOTA_GROWTH_Q4,
                                                      shadow_cfg.quota_retry_max);
                        quota_err_time = r.now_time;
                        quota_err_cnt  = '0;
                        quota_up       = 1'b1;
                    end else begin
                        h.answer = 1'b0;
                    end
                end
            end
            REQ_RECORD: begin
                if (r.send_result == RES_OK || r.send_result == RES_DISCARD) begin
                    settle_success(r.now_time, r.jitter);
                    h.answer = (credit_level < shadow_cfg.credit_trigger);
                end else if (r.send_result == RES_NET_FAIL) begin
                    net_err_time = r.now_time;
                    add_credit(1, r.now_time);
                    trip = count_failure(net_err_cnt, shadow_cfg.net_error_limit);
                    net_err_cnt = trip[7:0];
                    if (trip[8]) net_up = 1'b0;
                end else if (r.send_result == RES_QUOTA_FAIL) begin
                    quota_err_time = r.now_time;
                    credit_level   = 12'(CREDIT_FLOOR);
                    credit_stamp   = r.now_time;
                    trip = count_failure(quota_err_cnt, shadow_cfg.quota_error_limit);
                    quota_err_cnt = trip[7:0];
                    if (trip[8]) quota_up = 1'b0;
                end else begin
                    add_credit(1, r.now_time);
                end
            end
            REQ_RECOVER: begin
                if (r.region_match) begin
                    h.answer = !(net_up && quota_up);
                    settle_success(r.now_time, r.jitter);
                end
            end
            default: begin
                // Refill an exhausted credit after a long idle stretch
                elapsed = r.now_time - credit_stamp;
                if (credit_level == 12'd0 && elapsed > 32'(IDLE_REFILL_SECS)) begin
                    credit_level = 12'(CREDIT_FLOOR);
                    credit_stamp = r.now_time;
                end
                h.answer = (credit_level != 12'd0);
            end
        endcase
        h.network_ok = net_up;
        h.quota_ok   = quota_up;
        h.credit     = credit_level;
        return h;
    endfunction

    function automatic stim_row_t stim(input logic [1:0] kind, input logic [31:0] now,
                                       input logic [2:0] res, input logic [2:0] jit,
                                       input logic match);
        stim_row_t row;
        row = '{default: '0};
        row.req = '{req_type: kind, now_time: now, send_result: res, jitter: jit,
                    region_match: match};
        return row;
    endfunction

    function automatic stim_row_t stim_known(input logic [1:0] kind, input logic [31:0] now,
                                             input logic [2:0] res, input logic [2:0] jit,
                                             input logic match, input logic ans,
                                             input logic nok, input logic qok,
                                             input logic [11:0] cred);
        stim_row_t row;
        row = stim(kind, now, res, jit, match);
        row.known = 1'b1;
        row.want  = '{answer: ans, network_ok: nok, quota_ok: qok, credit: cred};
        return row;
    endfunction

    function automatic stim_row_t reg_write(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.is_write  = 1'b1;
        row.reg_idx   = idx;
        row.reg_value = value;
        return row;
    endfunction

    // Offer one request, wait for the transaction, queue its result
    task automatic send_request(input request_t r, input bit known, input health_t known_want);
        health_t want;
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {1'b0, r.region_match, r.jitter, r.send_result, r.now_time};
        do @(posedge aclk); while (!s_tready);
        want = next_health(r);
        expected_health.push_back(known ? known_want : want);
    endtask

    // Stop offering and wait until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_health.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_NET_ERROR_LIMIT:   shadow_cfg.net_error_limit   = value[7:0];
            REG_NET_RETRY_BASE:    shadow_cfg.net_retry_base    = value[15:0];
            REG_NET_RETRY_MAX:     shadow_cfg.net_retry_max     = value[15:0];
            REG_QUOTA_ERROR_LIMIT: shadow_cfg.quota_error_limit = value[7:0];
            REG_QUOTA_RETRY_BASE:  shadow_cfg.quota_retry_base  = value[15:0];
            REG_QUOTA_RETRY_MAX:   shadow_cfg.quota_retry_max   = value[15:0];
            REG_CREDIT_MAX:        shadow_cfg.credit_max        = value[11:0];
            default:               shadow_cfg.credit_trigger    = value[11:0];
        endcase
    endtask

    // Result side: check each transaction, apply random and long backpressure
    initial begin
        health_t     got;
        health_t     want;
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                // Unpack the result fields from the lowest bit up
                got.answer     = m_tdata[0];
                got.network_ok = m_tdata[1];
                got.quota_ok   = m_tdata[2];
                got.credit     = m_tdata[14:3];
                if (expected_health.size() == 0) begin
                    $error("result transaction with nothing pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_health.pop_front();
                    if (got.answer !== want.answer) begin
                        $error("answer: expected %0d, got %0d", want.answer, got.answer);
                        fail_count++;
                    end
                    if (got.network_ok !== want.network_ok) begin
                        $error("network_ok: expected %0d, got %0d",
                               want.network_ok, got.network_ok);
                        fail_count++;
                    end
                    if (got.quota_ok !== want.quota_ok) begin
                        $error("quota_ok: expected %0d, got %0d", want.quota_ok, got.quota_ok);
                        fail_count++;
                    end
                    if (got.credit !== want.credit) begin
                        $error("credit: expected %0d, got %0d", want.credit, got.credit);
                        fail_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_gap_pct);
            end
        end
    end

    initial begin
        stim_row_t   directed_rows[$];
        sbcc_cfg_t   next_cfg;
        request_t    r;
        logic [31:0] now_s;
        logic [2:0]  storm_res;
        int unsigned storm_left;
        int unsigned pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // Predictor starts from the reset values
        shadow_cfg = {RST_NET_ERROR_LIMIT, RST_NET_RETRY_BASE, RST_NET_RETRY_MAX,
                      RST_QUOTA_ERROR_LIMIT, RST_QUOTA_RETRY_BASE, RST_QUOTA_RETRY_MAX,
                      RST_CREDIT_MAX, RST_CREDIT_TRIGGER};
        net_err_cnt    = '0;
        quota_err_cnt  = '0;
        net_err_time   = '0;
        quota_err_time = '0;
        credit_stamp   = '0;
        net_backoff    = clamp_backoff(64'(shadow_cfg.net_retry_base) << BACKOFF_FRAC);
        quota_backoff  = clamp_backoff(64'(shadow_cfg.quota_retry_base) << BACKOFF_FRAC);
        net_up         = 1'b1;
        quota_up       = 1'b1;
        credit_level   = shadow_cfg.credit_max;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: reset state, extremes, every request kind and corner case
        directed_rows.push_back(stim_known(REQ_CAN_SEND, 32'd0, RES_OK, 3'd0, 1'b0,
                                           1'b1, 1'b1, 1'b1, 12'd512));
        directed_rows.push_back(stim_known(REQ_CONCURRENCY, 32'hFFFF_FFFF, RES_OK, 3'd0, 1'b0,
                                           1'b1, 1'b1, 1'b1, 12'd512));
        // jitter above range counts as the maximum
        directed_rows.push_back(stim_known(REQ_RECORD, 32'd10, RES_OK, 3'd7, 1'b0,
                                           1'b0, 1'b1, 1'b1, 12'd512));
        directed_rows.push_back(stim_known(REQ_RECORD, 32'd100, RES_QUOTA_FAIL, 3'd0, 1'b0,
                                           1'b0, 1'b1, 1'b0, 12'd1));
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'd106, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'd107, RES_OK, 3'd0, 1'b0));
        // unknown send result behaves as other
        directed_rows.push_back(stim(REQ_RECORD, 32'd108, 3'd7, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_RECORD, 32'd200, RES_DISCARD, 3'd0, 1'b0));
        directed_rows.push_back(stim_known(REQ_RECOVER, 32'd300, RES_OK, 3'd3, 1'b0,
                                           1'b0, 1'b1, 1'b1, 12'd4));
        directed_rows.push_back(reg_write(REG_NET_ERROR_LIMIT, 32'd1));
        directed_rows.push_back(reg_write(REG_NET_RETRY_BASE, 32'd1));
        directed_rows.push_back(reg_write(REG_NET_RETRY_MAX, 32'd65535));
        directed_rows.push_back(reg_write(REG_QUOTA_ERROR_LIMIT, 32'd255));
        directed_rows.push_back(stim(REQ_RECORD, 32'hFFFF_FFF0, RES_NET_FAIL, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_RECORD, 32'd5, RES_QUOTA_FAIL, 3'd0, 1'b0));
        // elapsed time wraps across zero
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'h100, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'h11C, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_RECOVER, 32'h200, RES_OK, 3'd4, 1'b1));
        // credit above a lowered maximum, then idle refill of an empty credit
        directed_rows.push_back(reg_write(REG_CREDIT_MAX, 32'd0));
        directed_rows.push_back(reg_write(REG_CREDIT_TRIGGER, 32'd4095));
        directed_rows.push_back(stim(REQ_RECORD, 32'h300, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_CONCURRENCY, 32'h32C, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_CONCURRENCY, 32'h32D, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_RECORD, 32'h400, RES_NET_FAIL, 3'd0, 1'b0));
        directed_rows.push_back(reg_write(REG_QUOTA_ERROR_LIMIT, 32'd1));
        directed_rows.push_back(stim(REQ_RECORD, 32'h401, RES_QUOTA_FAIL, 3'd0, 1'b0));
        // both breakers open: can-send looks at the network breaker only
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'h500, RES_OK, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_RECOVER, 32'h600, RES_OK, 3'd2, 1'b1));
        directed_rows.push_back(reg_write(REG_NET_ERROR_LIMIT, 32'd255));
        directed_rows.push_back(reg_write(REG_NET_RETRY_BASE, 32'd65535));
        directed_rows.push_back(reg_write(REG_NET_RETRY_MAX, 32'd1));
        directed_rows.push_back(reg_write(REG_QUOTA_ERROR_LIMIT, 32'd255));
        directed_rows.push_back(reg_write(REG_QUOTA_RETRY_BASE, 32'd65535));
        directed_rows.push_back(reg_write(REG_QUOTA_RETRY_MAX, 32'd65535));
        directed_rows.push_back(reg_write(REG_CREDIT_MAX, 32'd4095));
        directed_rows.push_back(reg_write(REG_CREDIT_TRIGGER, 32'd0));
        // quota interval saturates at the top of its range
        directed_rows.push_back(stim(REQ_RECORD, 32'h700, RES_OK, 3'd4, 1'b0));
        directed_rows.push_back(stim(REQ_RECORD, 32'h701, 3'd4, 3'd0, 1'b0));
        directed_rows.push_back(stim(REQ_CAN_SEND, 32'h702, RES_OK, 3'd0, 1'b0));

        src_gap_pct  = 8;
        sink_gap_pct = 66;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                drain();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].known,
                             directed_rows[i].want);
            end
        end

        // Random blocks, each under its own settings; the idling pattern changes every two blocks
        now_s      = '0;
        storm_left = 0;
        storm_res  = RES_NET_FAIL;
        for (int blk = 0; blk < 6; blk++) begin
            drain();
            case (blk)
                0: next_cfg = {8'd3, 16'd2, 16'd40, 8'd2, 16'd1, 16'd10, 12'd8, 12'd4};
                1: next_cfg = {8'd1, 16'd1, 16'd1, 8'd1, 16'd1, 16'd1, 12'd1, 12'd4095};
                2: next_cfg = {8'($urandom_range(1, 8)), 16'($urandom_range(1, 600)),
                               16'($urandom_range(1, 4000)), 8'($urandom_range(1, 8)),
                               16'($urandom_range(1, 60)), 16'($urandom_range(1, 600)),
                               12'($urandom_range(1, 64)), 12'($urandom_range(0, 64))};
                3: next_cfg = {8'd255, 16'd65535, 16'd65535, 8'd255, 16'd65535,
                               16'd65535, 12'd4095, 12'd0};
                4: next_cfg = {8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                               12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095))};
                default: next_cfg = {RST_NET_ERROR_LIMIT, RST_NET_RETRY_BASE,
                                     RST_NET_RETRY_MAX, RST_QUOTA_ERROR_LIMIT,
                                     RST_QUOTA_RETRY_BASE, RST_QUOTA_RETRY_MAX,
                                     RST_CREDIT_MAX, RST_CREDIT_TRIGGER};
            endcase
            write_reg(REG_NET_ERROR_LIMIT, 32'(next_cfg.net_error_limit));
            write_reg(REG_NET_RETRY_BASE, 32'(next_cfg.net_retry_base));
            write_reg(REG_NET_RETRY_MAX, 32'(next_cfg.net_retry_max));
            write_reg(REG_QUOTA_ERROR_LIMIT, 32'(next_cfg.quota_error_limit));
            write_reg(REG_QUOTA_RETRY_BASE, 32'(next_cfg.quota_retry_base));
            write_reg(REG_QUOTA_RETRY_MAX, 32'(next_cfg.quota_retry_max));
            write_reg(REG_CREDIT_MAX, 32'(next_cfg.credit_max));
            write_reg(REG_CREDIT_TRIGGER, 32'(next_cfg.credit_trigger));

            if (blk < 2) begin
                src_gap_pct  = 8;
                sink_gap_pct = 66;
            end else if (blk < 4) begin
                src_gap_pct  = 66;
                sink_gap_pct = 8;
            end else begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            // Stall the result side long enough to back up the input
            if (blk == 4) hold_request = 1'b1;
            // Cross the time wrap early in this block
            if (blk == 1) now_s = 32'hFFFF_F000;
            // Long failure run saturates the network error count
            if (blk == 3) begin
                storm_left = 260;
                storm_res  = RES_NET_FAIL;
            end

            for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: now_s = now_s + $urandom_range(3);
                    5, 6, 7:       now_s = now_s + $urandom_range(400);
                    8:             now_s = now_s + $urandom_range(70000);
                    default:       now_s = $urandom;
                endcase
                r.now_time     = now_s;
                r.jitter       = 3'($urandom_range(7));
                r.region_match = 1'($urandom_range(1));
                r.send_result  = 3'($urandom_range(7));
                if (storm_left > 0) begin
                    storm_left--;
                    r.req_type    = REQ_RECORD;
                    r.send_result = storm_res;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 3) begin
                        storm_left = $urandom_range(2, 20);
                        storm_res  = $urandom_range(1) ? RES_NET_FAIL : RES_QUOTA_FAIL;
                    end
                    if (pick < 33)      r.req_type = REQ_CAN_SEND;
                    else if (pick < 75) r.req_type = REQ_RECORD;
                    else if (pick < 85) r.req_type = REQ_RECOVER;
                    else                r.req_type = REQ_CONCURRENCY;
                    if (r.req_type == REQ_RECORD) begin
                        pick = $urandom_range(19);
                        if (pick < 4)       r.send_result = RES_OK;
                        else if (pick < 5)  r.send_result = RES_DISCARD;
                        else if (pick < 11) r.send_result = RES_NET_FAIL;
                        else if (pick < 17) r.send_result = RES_QUOTA_FAIL;
                        else                r.send_result = 3'($urandom_range(4, 7));
                    end
                end
                send_request(r, 1'b0, '0);
            end
        end

        // Wait out the pipeline and report
        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_health.size() == 0) begin
            $display("send_backoff_credit_controller regression: pass");
        end else begin
            $display("send_backoff_credit_controller regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbcc_pkg.sv
rtl/sbcc_cfg.sv
rtl/send_backoff_credit_controller.sv
verif/tb.sv
